@@ rtl/core/sah_pkg.sv @@
package sah_pkg;

  // default widths for the top-level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int MOD_W   = 16;
  localparam int RATE_W  = 17;
  localparam int DEPTH_W = 16;
  localparam int GAIN_W  = 32;
  localparam int INC_SHIFT = 16;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // arithmetic limits
  localparam int RATE_MIN       = 10;
  localparam int RATE_MAX       = 102400;
  localparam int DEPTH_ONE      = 32768;
  localparam int TRIG_THRESHOLD = 16384;

  // register reset values
  localparam logic [RATE_W-1:0]  BASE_RATE_RST  = RATE_W'(1024);
  localparam logic [DEPTH_W-1:0] BASE_DEPTH_RST = DEPTH_W'(32768);
  localparam logic [GAIN_W-1:0]  PHASE_GAIN_RST = GAIN_W'(5726623);

  // register indexes
  typedef enum logic [1:0] {
    REG_BASE_RATE  = 2'd0,
    REG_BASE_DEPTH = 2'd1,
    REG_PHASE_GAIN = 2'd2,
    REG_EXT_TRIG   = 2'd3
  } reg_idx_t;

endpackage

@@ rtl/core/sah_if.sv @@
// input word channel
interface sah_in_if #(
  parameter int SAMPLE_WIDTH = sah_pkg::SAMPLE_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_WIDTH-1:0]    sample;
  logic signed [sah_pkg::MOD_W-1:0]  rate_mod;
  logic signed [sah_pkg::MOD_W-1:0]  depth_mod;
  logic signed [sah_pkg::MOD_W-1:0]  trig_level;

  modport source (output valid, sample, rate_mod, depth_mod, trig_level, input ready);
  modport sink   (input valid, sample, rate_mod, depth_mod, trig_level, output ready);
endinterface

// result word channel
interface sah_out_if #(
  parameter int SAMPLE_WIDTH = sah_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] held_value;
  logic                           fired;

  modport source (output valid, held_value, fired, input ready);
  modport sink   (input valid, held_value, fired, output ready);
endinterface

@@ rtl/core/sample_and_hold_clocked_unit.sv @@
// clocked sample and hold, internal phase clock or external trigger edges
// throughput: one word per cycle, three register stages (clamp, multiply, state update)
// the input side keeps accepting while a result waits, until all three stages are full
// reset (rst_n low, synchronous): pipeline empty, phase 0, held 0, trigger taken as low,
// configuration registers back to their defaults
module sample_and_hold_clocked_unit #(
  parameter int SAMPLE_WIDTH = sah_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = sah_pkg::PHASE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sah_in_if.sink                       in_word,
  sah_out_if.source                    out_word,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sah_pkg::ADDR_W-1:0]   paddr,
  input  logic [sah_pkg::DATA_W-1:0]   pwdata,
  output logic [sah_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int RATE_W  = sah_pkg::RATE_W;
  localparam int DEPTH_W = sah_pkg::DEPTH_W;
  localparam int GAIN_W  = sah_pkg::GAIN_W;
  localparam int MOD_W   = sah_pkg::MOD_W;
  localparam int DATA_W  = sah_pkg::DATA_W;
  localparam int MUL_W   = RATE_W + GAIN_W;
  localparam int INC_W   = MUL_W - sah_pkg::INC_SHIFT;
  localparam int SUM_W   = ((PHASE_WIDTH > INC_W) ? PHASE_WIDTH : INC_W) + 1;
  localparam int RSUM_W  = RATE_W + 2;
  localparam int DSUM_W  = DEPTH_W + 2;
  localparam int PROD_W  = SAMPLE_WIDTH + DEPTH_W + 1;

  localparam logic signed [RSUM_W-1:0] RATE_MIN_S  = RSUM_W'(sah_pkg::RATE_MIN);
  localparam logic signed [RSUM_W-1:0] RATE_MAX_S  = RSUM_W'(sah_pkg::RATE_MAX);
  localparam logic signed [DSUM_W-1:0] DEPTH_ONE_S = DSUM_W'(sah_pkg::DEPTH_ONE);
  localparam logic signed [MOD_W-1:0]  TRIG_TH_S   = MOD_W'(sah_pkg::TRIG_THRESHOLD);

  // configuration registers
  logic [RATE_W-1:0]  base_rate_r;
  logic [DEPTH_W-1:0] base_depth_r;
  logic [GAIN_W-1:0]  phase_gain_r;
  logic               ext_trig_r;

  logic                   cfg_wr;
  sah_pkg::reg_idx_t      cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sah_pkg::reg_idx_t'(paddr[sah_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rate_r  <= sah_pkg::BASE_RATE_RST;
      base_depth_r <= sah_pkg::BASE_DEPTH_RST;
      phase_gain_r <= sah_pkg::PHASE_GAIN_RST;
      ext_trig_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sah_pkg::REG_BASE_RATE:  base_rate_r  <= pwdata[RATE_W-1:0];
        sah_pkg::REG_BASE_DEPTH: base_depth_r <= pwdata[DEPTH_W-1:0];
        sah_pkg::REG_PHASE_GAIN: phase_gain_r <= pwdata[GAIN_W-1:0];
        sah_pkg::REG_EXT_TRIG:   ext_trig_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      sah_pkg::REG_BASE_RATE:  prdata = DATA_W'(base_rate_r);
      sah_pkg::REG_BASE_DEPTH: prdata = DATA_W'(base_depth_r);
      sah_pkg::REG_PHASE_GAIN: prdata = DATA_W'(phase_gain_r);
      sah_pkg::REG_EXT_TRIG:   prdata = DATA_W'(ext_trig_r);
      default:                 prdata = '0;
    endcase
  end

  // stage handshake: each stage loads when it is empty or the next one loads
  logic v1_r, v2_r, out_valid_r;
  logic ld1, ld2, ld3, in_acc;

  assign ld3    = !out_valid_r || out_word.ready;
  assign ld2    = !v2_r || ld3;
  assign ld1    = !v1_r || ld2;
  assign in_acc = in_word.valid && ld1;
  assign in_word.ready = ld1;

  // effective rate: base + floor(mod * 5 / 8), clamped
  logic signed [RSUM_W-1:0] rmod_x5;
  logic signed [MOD_W-1:0]  rmod_adj;
  logic signed [RSUM_W-1:0] rate_sum;
  logic [RATE_W-1:0]        rate_nxt;

  always_comb begin
    rmod_x5  = RSUM_W'(in_word.rate_mod) + (RSUM_W'(in_word.rate_mod) <<< 2);
    rmod_adj = rmod_x5[MOD_W+2:3];
    rate_sum = $signed({2'b00, base_rate_r}) + RSUM_W'(rmod_adj);
    if (rate_sum < RATE_MIN_S) begin
      rate_nxt = RATE_W'(sah_pkg::RATE_MIN);
    end else if (rate_sum > RATE_MAX_S) begin
      rate_nxt = RATE_W'(sah_pkg::RATE_MAX);
    end else begin
      rate_nxt = rate_sum[RATE_W-1:0];
    end
  end

  // effective depth: base + mod, clamped to 0..1.0
  logic signed [DSUM_W-1:0] depth_sum;
  logic [DEPTH_W-1:0]       depth_nxt;

  always_comb begin
    depth_sum = $signed({2'b00, base_depth_r}) + DSUM_W'(in_word.depth_mod);
    if (depth_sum < 0) begin
      depth_nxt = '0;
    end else if (depth_sum > DEPTH_ONE_S) begin
      depth_nxt = DEPTH_W'(sah_pkg::DEPTH_ONE);
    end else begin
      depth_nxt = depth_sum[DEPTH_W-1:0];
    end
  end

  // stage 1: clamped rate and depth, sample and trigger level compare
  logic [RATE_W-1:0]              rate1_r;
  logic [DEPTH_W-1:0]             depth1_r;
  logic signed [SAMPLE_WIDTH-1:0] sample1_r;
  logic                           high1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ld1) begin
      v1_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rate1_r   <= rate_nxt;
      depth1_r  <= depth_nxt;
      sample1_r <= in_word.sample;
      high1_r   <= (in_word.trig_level >= TRIG_TH_S);
    end
  end

  // stage 2: phase increment and scaled sample
  logic [MUL_W-1:0]               inc_full;
  logic signed [PROD_W-1:0]       prod_full;
  logic [INC_W-1:0]               inc2_r;
  logic signed [SAMPLE_WIDTH-1:0] scaled2_r;
  logic                           high2_r;

  assign inc_full  = MUL_W'(rate1_r) * MUL_W'(phase_gain_r);
  assign prod_full = PROD_W'(sample1_r) * $signed({1'b0, depth1_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ld2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      inc2_r    <= inc_full[MUL_W-1:sah_pkg::INC_SHIFT];
      scaled2_r <= prod_full[SAMPLE_WIDTH+14:15];
      high2_r   <= high1_r;
    end
  end

  // stage 3: trigger decision and state update
  logic [PHASE_WIDTH-1:0]         phase_acc_r;
  logic                           trig_was_low_r;
  logic signed [SAMPLE_WIDTH-1:0] held_r;
  logic                           fired_r;
  logic [SUM_W-1:0]               phase_sum;
  logic                           fire_c;

  always_comb begin
    phase_sum = SUM_W'(phase_acc_r) + SUM_W'(inc2_r);
    if (ext_trig_r) begin
      fire_c = trig_was_low_r && high2_r;
    end else begin
      fire_c = |phase_sum[SUM_W-1:PHASE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      fired_r        <= 1'b0;
      phase_acc_r    <= '0;
      trig_was_low_r <= 1'b1;
      held_r         <= '0;
    end else if (ld3) begin
      out_valid_r <= v2_r;
      if (v2_r) begin
        fired_r <= fire_c;
        if (fire_c) begin
          held_r <= scaled2_r;
        end
        if (ext_trig_r) begin
          trig_was_low_r <= !high2_r;
        end else begin
          phase_acc_r <= phase_sum[PHASE_WIDTH-1:0];
        end
      end
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.held_value = held_r;
  assign out_word.fired      = fired_r;

`ifndef SYNTHESIS
  // input side only stalls when every stage holds a word
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_word.ready |-> (v1_r && v2_r && out_valid_r))
    else $error("input stalled with an empty stage");

  // held value changes only on a trigger
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ld3 && v2_r && !fire_c) |=> (held_r == $past(held_r)))
    else $error("held value changed without a trigger");

  // phase is frozen in external mode
  a_phase_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (ld3 && v2_r && ext_trig_r) |=> $stable(phase_acc_r))
    else $error("phase moved in external trigger mode");

  // edge detector tracks the last level in external mode
  a_edge_track: assert property (@(posedge clk) disable iff (!rst_n)
    (ld3 && v2_r && ext_trig_r) |=> (trig_was_low_r == !$past(high2_r)))
    else $error("trigger level history not updated");
`endif

endmodule
